// ===== rtl/melody_note_sequencer_top_defines.svh =====
// Assertion helpers used by the sequencer controller (mns_ctrl).
`ifndef MELODY_NOTE_SEQUENCER_TOP_DEFINES_SVH
`define MELODY_NOTE_SEQUENCER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MNS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mns_pkg.sv =====
`timescale 1ns / 1ps

package mns_pkg;

    localparam int OP_W        = 2;
    localparam int EIDX_W      = 6;
    localparam int PITCH_W     = 4;
    localparam int OCT_W       = 4;
    localparam int DIVN_W      = 7;
    localparam int TIES_W      = 8;
    localparam int DUR_W       = 26;
    localparam int TEMPO_W     = 10;
    localparam int LEN_W       = 7;
    localparam int LOOP_W      = 6;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 10;

    // Divider: 240000 / (tempo * division), one quotient bit per cycle.
    localparam int DIVISOR_W   = TEMPO_W + DIVN_W;
    localparam int QUO_W       = 18;
    localparam int DIV_CNT_W   = 5;
    localparam logic [QUO_W-1:0] WHOLE_NOTE_MS = 18'd240000;

    localparam logic [TEMPO_W-1:0] TEMPO_RESET = 10'd120;
    localparam logic [LEN_W-1:0]   LENGTH_RESET = 7'd1;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE   = 2'd0,
        OP_PLAY    = 2'd1,
        OP_RESTART = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TEMPO      = 2'd0,
        CFG_LENGTH     = 2'd1,
        CFG_LOOP_EN    = 2'd2,
        CFG_LOOP_START = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PROG_READY    = 2'd0,
        PROG_PLAYING  = 2'd1,
        PROG_NEXT     = 2'd2,
        PROG_FINISHED = 2'd3
    } t_progress;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_MUL,
        S_DIV,
        S_PROD,
        S_OUT
    } t_ctl_state;

    typedef enum logic [1:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_NEXT,
        IDX_LOOP
    } t_idx_op;

    typedef struct packed {
        logic [TIES_W-1:0]  ties;
        logic [DIVN_W-1:0]  division;
        logic [OCT_W-1:0]   octave;
        logic [PITCH_W-1:0] pitch;
    } t_entry;

    typedef struct packed {
        logic    wr_entry;
        t_idx_op idx_op;
        logic    mul;
        logic    div_start;
        logic    div_step;
        logic    prod;
        logic    out_load;
        logic    fin;
        logic    fresh;
        logic    silence;
    } t_dp_cmd;

    typedef struct packed {
        logic at_end;
        logic loop_en;
        logic div_last;
        logic out_stall;
    } t_dp_status;

endpackage

// ===== rtl/mns_if.sv =====
`timescale 1ns / 1ps

interface mns_in_if import mns_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [EIDX_W-1:0]  entry_index;
    logic [PITCH_W-1:0] entry_pitch;
    logic [OCT_W-1:0]   entry_octave;
    logic [DIVN_W-1:0]  entry_division;
    logic [TIES_W-1:0]  entry_ties;
    logic               note_done;

    modport source (
        output valid, opcode, entry_index, entry_pitch, entry_octave,
               entry_division, entry_ties, note_done,
        input  ready
    );
    modport sink (
        input  valid, opcode, entry_index, entry_pitch, entry_octave,
               entry_division, entry_ties, note_done,
        output ready
    );
endinterface

interface mns_out_if import mns_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               finished;
    logic               note_loaded;
    logic               silence_cmd;
    logic [PITCH_W-1:0] note_pitch;
    logic [OCT_W-1:0]   note_octave;
    logic [DUR_W-1:0]   note_duration_ms;

    modport source (
        output valid, finished, note_loaded, silence_cmd, note_pitch, note_octave,
               note_duration_ms,
        input  ready
    );
    modport sink (
        input  valid, finished, note_loaded, silence_cmd, note_pitch, note_octave,
               note_duration_ms,
        output ready
    );
endinterface

interface mns_cfg_if import mns_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mns_ctrl.sv =====
`timescale 1ns / 1ps
`include "melody_note_sequencer_top_defines.svh"

module mns_ctrl import mns_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [OP_W-1:0] i_opcode,
    input  logic            i_note_done,
    input  t_dp_status      i_status,
    output logic            o_in_ready,
    output t_dp_cmd         o_cmd
);

    t_ctl_state r_state, n_state;
    t_progress  r_progress, n_progress;
    logic       r_fin, n_fin;
    logic       r_fresh, n_fresh;
    logic       r_sil, n_sil;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_progress <= PROG_READY;
            r_fin      <= 1'b0;
            r_fresh    <= 1'b0;
            r_sil      <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_progress <= n_progress;
            r_fin      <= n_fin;
            r_fresh    <= n_fresh;
            r_sil      <= n_sil;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_progress = r_progress;
        n_fin      = r_fin;
        n_fresh    = r_fresh;
        n_sil      = r_sil;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.idx_op = IDX_HOLD;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_fin   = 1'b0;
                    n_fresh = 1'b0;
                    n_sil   = 1'b0;
                    n_state = S_OUT;
                    case (t_opcode'(i_opcode))
                        OP_WRITE: begin
                            o_cmd.wr_entry = 1'b1;
                        end
                        OP_RESTART: begin
                            n_progress = PROG_READY;
                        end
                        OP_PLAY: begin
                            case (r_progress)
                                PROG_READY: begin
                                    o_cmd.idx_op = IDX_ZERO;
                                    n_fresh      = 1'b1;
                                    n_progress   = PROG_PLAYING;
                                    n_state      = S_READ;
                                end
                                PROG_PLAYING: begin
                                    if (i_note_done) begin
                                        n_sil      = 1'b1;
                                        n_progress = PROG_NEXT;
                                    end
                                end
                                PROG_NEXT: begin
                                    // Advance to the next note; past the end of the song: loop back or stop.
                                    if (i_status.at_end && !i_status.loop_en) begin
                                        n_sil      = 1'b1;
                                        n_progress = PROG_FINISHED;
                                    end else begin
                                        o_cmd.idx_op = i_status.at_end ? IDX_LOOP : IDX_NEXT;
                                        n_fresh      = 1'b1;
                                        n_progress   = PROG_PLAYING;
                                        n_state      = S_READ;
                                    end
                                end
                                default: begin
                                    n_fin = 1'b1;
                                end
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul       = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_cmd.fin     = r_fin;
                o_cmd.fresh   = r_fresh;
                o_cmd.silence = r_sil;
                if (!i_status.out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `MNS_ASSERT_NEXT(a_div_runs, i_clk, i_rst_n, r_state == S_DIV && !i_status.div_last, r_state == S_DIV, "divider sequence cut short")
    `MNS_ASSERT_SAME(a_fresh_playing, i_clk, i_rst_n, r_state == S_OUT && r_fresh, r_progress == PROG_PLAYING, "new note without playing state")
    `MNS_ASSERT_SAME(a_fin_alone, i_clk, i_rst_n, r_state == S_OUT && r_fin, !r_fresh && !r_sil && r_progress == PROG_FINISHED, "finished flag mixed with others")
    `MNS_ASSERT_NEXT(a_out_done, i_clk, i_rst_n, r_state == S_OUT && !i_status.out_stall, r_state == S_IDLE, "result sent but not back to idle")

endmodule

// ===== rtl/mns_dp.sv =====
`timescale 1ns / 1ps

module mns_dp import mns_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [EIDX_W-1:0]  i_entry_index,
    input  logic [PITCH_W-1:0] i_entry_pitch,
    input  logic [OCT_W-1:0]   i_entry_octave,
    input  logic [DIVN_W-1:0]  i_entry_division,
    input  logic [TIES_W-1:0]  i_entry_ties,
    output t_dp_status         o_status,
    mns_cfg_if.sink            i_cfg,
    mns_out_if.source          o_out
);

    localparam int IDX_W     = $clog2(TABLE_DEPTH);
    localparam int SLOT_SPAN = 1 << EIDX_W;
    localparam int CMP_W     = (IDX_W + 1 > LEN_W) ? IDX_W + 1 : LEN_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Table from a 6-bit slot number to its place in a table of any depth.
    typedef logic [SLOT_SPAN-1:0][IDX_W-1:0] t_wrap_lut;

    function automatic t_wrap_lut build_wrap_lut();
        t_wrap_lut lut;
        for (int i = 0; i < SLOT_SPAN; i++) begin
            lut[i] = IDX_W'(i % TABLE_DEPTH);
        end
        return lut;
    endfunction

    localparam t_wrap_lut WRAP_LUT = build_wrap_lut();

    logic [TEMPO_W-1:0]   r_tempo;
    logic [LEN_W-1:0]     r_song_len;
    logic                 r_loop_en;
    logic [LOOP_W-1:0]    r_loop_start;
    logic [IDX_W-1:0]     r_play_index;
    t_entry               r_table [TABLE_DEPTH];
    t_entry               r_rd_entry;
    logic [DIVISOR_W-1:0] r_divisor;
    logic [DIVISOR_W-1:0] r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DIV_CNT_W-1:0] r_div_cnt;
    logic [PITCH_W-1:0]   r_cur_pitch;
    logic [OCT_W-1:0]     r_cur_octave;
    logic [DUR_W-1:0]     r_cur_duration;
    logic                 r_out_valid;
    logic                 r_out_fin;
    logic                 r_out_fresh;
    logic                 r_out_sil;
    logic [PITCH_W-1:0]   r_out_pitch;
    logic [OCT_W-1:0]     r_out_octave;
    logic [DUR_W-1:0]     r_out_duration;

    logic [IDX_W-1:0]           next_idx;
    logic [CMP_W-1:0]           len_clamped;
    logic [DIVISOR_W-1:0]       divisor_full;
    logic [DIVISOR_W:0]         trial;
    logic                       trial_fits;
    logic [QUO_W+TIES_W-1:0]    dur_full;
    t_entry                     wr_entry;

    // Configuration registers; writes are always taken.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo      <= TEMPO_RESET;
            r_song_len   <= LENGTH_RESET;
            r_loop_en    <= 1'b0;
            r_loop_start <= '0;
        end else if (i_cfg.valid) begin
            case (t_cfg_reg'(i_cfg.index))
                CFG_TEMPO:      r_tempo      <= i_cfg.data[TEMPO_W-1:0];
                CFG_LENGTH:     r_song_len   <= i_cfg.data[LEN_W-1:0];
                CFG_LOOP_EN:    r_loop_en    <= i_cfg.data[0];
                CFG_LOOP_START: r_loop_start <= i_cfg.data[LOOP_W-1:0];
                default: ;
            endcase
        end
    end

    // Play index and end-of-song detection.
    assign next_idx    = (r_play_index == LAST_IDX) ? '0 : r_play_index + 1'b1;
    assign len_clamped = (CMP_W'(r_song_len) > CMP_W'(TABLE_DEPTH)) ?
                         CMP_W'(TABLE_DEPTH) : CMP_W'(r_song_len);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_play_index <= '0;
        end else begin
            case (i_cmd.idx_op)
                IDX_ZERO: r_play_index <= '0;
                IDX_NEXT: r_play_index <= next_idx;
                IDX_LOOP: r_play_index <= WRAP_LUT[r_loop_start];
                default: ;
            endcase
        end
    end

    // Note table: one write port, one registered read at the play index.
    assign wr_entry.ties     = i_entry_ties;
    assign wr_entry.division = i_entry_division;
    assign wr_entry.octave   = i_entry_octave;
    assign wr_entry.pitch    = i_entry_pitch;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_entry) begin
            r_table[WRAP_LUT[i_entry_index]] <= wr_entry;
        end
        r_rd_entry <= r_table[r_play_index];
    end

    // Divisor product, forced to one when zero.
    assign divisor_full = DIVISOR_W'(r_tempo) * DIVISOR_W'(r_rd_entry.division);

    // Restoring divider step.
    assign trial      = {r_rem, r_quo[QUO_W-1]};
    assign trial_fits = trial >= {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            r_divisor <= (divisor_full == '0) ? DIVISOR_W'(1) : divisor_full;
        end
        if (i_cmd.div_start) begin
            r_rem     <= '0;
            r_quo     <= WHOLE_NOTE_MS;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem     <= trial_fits ? DIVISOR_W'(trial - {1'b0, r_divisor})
                                    : trial[DIVISOR_W-1:0];
            r_quo     <= {r_quo[QUO_W-2:0], trial_fits};
            r_div_cnt <= r_div_cnt + 1'b1;
        end
    end

    assign dur_full = r_quo * r_rd_entry.ties;

    // Current note.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_pitch    <= '0;
            r_cur_octave   <= '0;
            r_cur_duration <= '0;
        end else if (i_cmd.prod) begin
            r_cur_pitch    <= r_rd_entry.pitch;
            r_cur_octave   <= r_rd_entry.octave;
            r_cur_duration <= dur_full[DUR_W-1:0];
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_fin      <= i_cmd.fin;
            r_out_fresh    <= i_cmd.fresh;
            r_out_sil      <= i_cmd.silence;
            r_out_pitch    <= r_cur_pitch;
            r_out_octave   <= r_cur_octave;
            r_out_duration <= r_cur_duration;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.finished         = r_out_fin;
    assign o_out.note_loaded      = r_out_fresh;
    assign o_out.silence_cmd      = r_out_sil;
    assign o_out.note_pitch       = r_out_pitch;
    assign o_out.note_octave      = r_out_octave;
    assign o_out.note_duration_ms = r_out_duration;

    assign o_status.at_end    = (r_play_index == LAST_IDX) ||
                                (CMP_W'(next_idx) >= len_clamped);
    assign o_status.loop_en   = r_loop_en;
    assign o_status.div_last  = r_div_cnt == DIV_CNT_W'(QUO_W - 1);
    assign o_status.out_stall = r_out_valid && !o_out.ready;

endmodule

// ===== rtl/melody_note_sequencer_top.sv =====
`timescale 1ns / 1ps

// Melody note sequencer: walks a table of notes written through the input
// channel and returns one result per input transfer. A play step that loads a
// note runs a table read, divisor multiply, 18 restoring-divider steps for
// 240000 / (tempo * division) and a tie multiply before the result register;
// every other step goes straight to the result register, which waits while
// the previous result is still unread. The iterative divider, one quotient
// bit per cycle, sets the load time. A new input is taken while the previous
// result still waits in the output register. Configuration writes are always
// accepted and must only be issued while the block is idle.
module melody_note_sequencer_top import mns_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mns_in_if.sink     i_in,
    mns_cfg_if.sink    i_cfg,
    mns_out_if.source  o_out
);

    t_dp_cmd    dp_cmd;
    t_dp_status dp_status;
    logic       in_ready;

    assign i_in.ready = in_ready;

    mns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (i_in.opcode),
        .i_note_done (i_in.note_done),
        .i_status    (dp_status),
        .o_in_ready  (in_ready),
        .o_cmd       (dp_cmd)
    );

    mns_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .i_entry_index    (i_in.entry_index),
        .i_entry_pitch    (i_in.entry_pitch),
        .i_entry_octave   (i_in.entry_octave),
        .i_entry_division (i_in.entry_division),
        .i_entry_ties     (i_in.entry_ties),
        .o_status         (dp_status),
        .i_cfg            (i_cfg),
        .o_out            (o_out)
    );

endmodule
